// File: hdl/swkr_pkg.sv
// ----------------------------------------------------------------------------
// swkr_pkg: shared types and constants for the keyed-removal stack
// Sizes, command and status codes, sequencer states and word structs.
// ----------------------------------------------------------------------------
package swkr_pkg;

    localparam int DEPTH   = 8;
    localparam int KEY_W   = 56;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MOVES_W = 6;
    localparam int OCC_W   = 7;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_NOTFOUND
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_POP,
        SEQ_SEARCH,
        SEQ_SHIFT
    } seq_state_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] plate_key;
    } swkr_cmd_t;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   popped_key;
        logic [MOVES_W-1:0] moves;
        logic [OCC_W-1:0]   occupancy;
    } swkr_res_t;

endpackage

// File: hdl/swkr_ram.sv
// ----------------------------------------------------------------------------
// swkr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swkr_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/stack_with_keyed_removal_core.sv
// ----------------------------------------------------------------------------
// stack_with_keyed_removal_core: bounded stack of 56-bit keys
// Push, pop and remove-by-key over one RAM, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Push, the unused code and a pop or remove on an empty stack give their word
// in the cycle after start; a pop otherwise passes through SEQ_POP first.
// Remove searches top-down in SEQ_SEARCH, then moves the entries above the
// match down in SEQ_SHIFT; one RAM read port is shared by search and shift.
// busy stays high until the result strobe; one command at a time.
// Reset: occupancy zero; entries undefined until written, no clearing pass.
module stack_with_keyed_removal_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  swkr_pkg::swkr_cmd_t command,
    output logic               busy,
    output logic               done,
    output swkr_pkg::swkr_res_t result
);
    import swkr_pkg::*;

    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);

    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [MOVES_W-1:0] moves_reg, moves_next;
    swkr_res_t          res_reg, res_next;
    logic               done_reg, done_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [KEY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [KEY_W-1:0]   ram_rdata;

    logic [ADDR_W-1:0]  top_idx;
    logic [CNT_W-1:0]   count_dec;

    function automatic swkr_res_t make_res(input status_t st, input logic [KEY_W-1:0] k,
                                           input logic [MOVES_W-1:0] mv,
                                           input logic [CNT_W-1:0] cnt);
        swkr_res_t r;
        r.status     = st;
        r.popped_key = k;
        r.moves      = mv;
        r.occupancy  = OCC_W'(cnt);
        return r;
    endfunction

    swkr_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_dec = count_reg - CNT_ONE;
    assign top_idx   = ADDR_W'(count_dec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        key_reg   <= key_next;
        moves_reg <= moves_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        moves_next = moves_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = ADDR_W'(count_reg);
        ram_wdata  = command.plate_key;
        ram_raddr  = top_idx;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    key_next = command.plate_key;
                    case (command.cmd)
                        CMD_PUSH:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_FULL)
                            begin
                                res_next = make_res(ST_FULL, '0, '0, count_reg);
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_ONE;
                                res_next   = make_res(ST_OK, '0, '0, count_reg + CNT_ONE);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                res_next  = make_res(ST_EMPTY, '0, '0, count_reg);
                            end
                            else
                            begin
                                state_next = SEQ_POP;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                res_next  = make_res(ST_NOTFOUND, '0, '0, count_reg);
                            end
                            else
                            begin
                                idx_next   = top_idx;
                                state_next = SEQ_SEARCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_next  = make_res(ST_OK, '0, '0, count_reg);
                        end
                    endcase
                end
            end
            SEQ_POP:
            begin
                count_next = count_dec;
                done_next  = 1'b1;
                res_next   = make_res(ST_OK, ram_rdata, '0, count_dec);
                state_next = SEQ_IDLE;
            end
            SEQ_SEARCH:
            begin
                if (ram_rdata == key_reg)
                begin
                    moves_next = MOVES_W'(top_idx - idx_reg);
                    if (idx_reg == top_idx)
                    begin
                        count_next = count_dec;
                        done_next  = 1'b1;
                        res_next   = make_res(ST_OK, '0, '0, count_dec);
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_ONE;
                        ram_raddr  = idx_reg + ADDR_ONE;
                        state_next = SEQ_SHIFT;
                    end
                end
                else if (idx_reg == '0)
                begin
                    done_next  = 1'b1;
                    res_next   = make_res(ST_NOTFOUND, '0, '0, count_reg);
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg - ADDR_ONE;
                    ram_raddr = idx_reg - ADDR_ONE;
                end
            end
            SEQ_SHIFT:
            begin
                // move entry idx down by one slot
                ram_we    = 1'b1;
                ram_waddr = idx_reg - ADDR_ONE;
                ram_wdata = ram_rdata;
                if (idx_reg == top_idx)
                begin
                    count_next = count_dec;
                    done_next  = 1'b1;
                    res_next   = make_res(ST_OK, '0, moves_reg, count_dec);
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg + ADDR_ONE;
                    ram_raddr = idx_reg + ADDR_ONE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != SEQ_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("occupancy above depth");

    a_we_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == SEQ_SHIFT) || (start && !busy))
        else $error("RAM write outside push or shift");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command.cmd == CMD_PUSH && count_reg != CNT_FULL)
        |=> (count_reg == $past(count_reg) + CNT_ONE) && done)
        else $error("push did not grow the stack");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command.cmd == CMD_POP && count_reg == '0)
        |=> done && (result.status == ST_EMPTY) && (result.popped_key == '0))
        else $error("pop on empty stack misreported");

    a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_SHIFT) |-> (idx_reg != '0) && (count_reg != '0))
        else $error("shift index out of range");
`endif

endmodule
